### rtl/core/run_row_renderer_defines.svh
// Assertion macros used by the renderer control RTL (rrr_ctrl).
`ifndef RUN_ROW_RENDERER_DEFINES_SVH
`define RUN_ROW_RENDERER_DEFINES_SVH
`ifndef SYNTH
// Check that a condition holds whenever the trigger holds, in the same cycle.
`define RRR_ASSERT_SAME(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rrr: same-cycle check failed");
// Check that a condition holds in the cycle after the trigger.
`define RRR_ASSERT_NEXT(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rrr: next-cycle check failed");
`else
`define RRR_ASSERT_SAME(name, clk, rst_n, trig, cond)
`define RRR_ASSERT_NEXT(name, clk, rst_n, trig, cond)
`endif
`endif

### rtl/core/rrr_pkg.sv
package rrr_pkg;

    localparam int LINE_DEPTH    = 1024;
    localparam int PALETTE_DEPTH = 256;
    localparam int LINE_AW       = $clog2(LINE_DEPTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int COL_W         = 11;
    localparam int LABEL_W       = 16;
    localparam int WORD_W        = 32;

    localparam logic [WORD_W-1:0] MASK_VALUE = 32'h0000_00FF;

    // request kinds
    localparam logic [1:0] REQ_START_ROW = 2'd0;
    localparam logic [1:0] REQ_PAINT_RUN = 2'd1;
    localparam logic [1:0] REQ_PAL_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ_PIX  = 2'd3;

    // display modes
    localparam logic [1:0] MODE_LABEL   = 2'd0;
    localparam logic [1:0] MODE_MASK    = 2'd1;
    localparam logic [1:0] MODE_PALETTE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLAMPED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] REG_LABEL_OFFSET = 2'd1;
    localparam logic [1:0] REG_BACKGROUND   = 2'd2;
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd3;

    typedef struct packed {
        logic [1:0]        display_mode;
        logic              label_offset;
        logic [WORD_W-1:0] background_value;
        logic [COL_W-1:0]  row_width;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COL_W-1:0]   run_first;
        logic [COL_W-1:0]   run_end;
        logic [LABEL_W-1:0] run_label;
        logic [WORD_W-1:0]  color_word;
    } in_item_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [LINE_AW-1:0] addr;
        logic [WORD_W-1:0]  wdata;
    } line_req_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PAL_AW-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } pal_req_t;

endpackage

### rtl/core/run_row_renderer.sv
// Run row renderer. Paints one image row at a time into a 1024-word line
// buffer from labelled horizontal runs, with a 256-entry palette memory for
// colour mode. Each request returns exactly one response on the master side.
// Request kinds (s_tuser): start row fills columns 0..width-1 with the
// background word; paint run writes columns first..end-1 with label+offset,
// 0xFF (mask) or a palette word; palette write stores color_word; read pixel
// returns the stored word. Width in use is row_width saturated to the line
// depth. Timing is set by the single write port of the line buffer, which
// takes one column per cycle: start row sweeps its columns, a run sweeps
// its columns after a palette read and wait in colour mode, palette writes
// write once, and pixel reads read then wait. A new request is taken
// while the previous response still waits on m_tready. Both memories power
// up undefined: there is no clearing pass, and reading an unwritten column
// or palette entry returns garbage. Configuration writes must only be made
// while no request is in flight.
module run_row_renderer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // run_first[10:0], run_end[21:11], run_label[37:22],
                                   // color_word[69:38], zero pad[71:70]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // response channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import rrr_pkg::*;

    cfg_t             cfg;
    in_item_t         in_item;
    line_req_t        line_req;
    pal_req_t         pal_req;
    logic [WORD_W-1:0] line_rdata;
    logic [WORD_W-1:0] pal_rdata;

    // unpack the request fields
    always_comb
    begin
        in_item.req_type   = s_tuser;
        in_item.run_first  = s_tdata[10:0];
        in_item.run_end    = s_tdata[21:11];
        in_item.run_label  = s_tdata[37:22];
        in_item.color_word = s_tdata[69:38];
    end

    rrr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rrr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (m_tdata),
        .out_status (m_tuser),
        .line_req   (line_req),
        .line_rdata (line_rdata),
        .pal_req    (pal_req),
        .pal_rdata  (pal_rdata)
    );

    // line buffer: one column per cycle, read data registered and valid in the cycle after the request
    rrr_ram #(
        .DEPTH  (LINE_DEPTH),
        .DATA_W (WORD_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_req.we),
        .re    (line_req.re),
        .addr  (line_req.addr),
        .wdata (line_req.wdata),
        .rdata (line_rdata)
    );

    // palette memory
    rrr_ram #(
        .DEPTH  (PALETTE_DEPTH),
        .DATA_W (WORD_W)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_req.we),
        .re    (pal_req.re),
        .addr  (pal_req.addr),
        .wdata (pal_req.wdata),
        .rdata (pal_rdata)
    );

endmodule

### rtl/core/rrr_ram.sv
module rrr_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rrr_cfg.sv
module rrr_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output rrr_pkg::cfg_t cfg
);
    import rrr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_mode     <= MODE_LABEL;
            cfg_reg.label_offset     <= 1'b1;
            cfg_reg.background_value <= '0;
            cfg_reg.row_width        <= COL_W'(LINE_DEPTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DISPLAY_MODE: cfg_reg.display_mode     <= cfg_wdata[1:0];
                REG_LABEL_OFFSET: cfg_reg.label_offset     <= cfg_wdata[0];
                REG_BACKGROUND:   cfg_reg.background_value <= cfg_wdata;
                REG_ROW_WIDTH:    cfg_reg.row_width        <= cfg_wdata[COL_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/rrr_ctrl.sv
`include "run_row_renderer_defines.svh"

module rrr_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrr_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rrr_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rrr_pkg::WORD_W-1:0]   out_pixel,
    output logic [1:0]                   out_status,
    output rrr_pkg::line_req_t           line_req,
    input  logic [rrr_pkg::WORD_W-1:0]   line_rdata,
    output rrr_pkg::pal_req_t            pal_req,
    input  logic [rrr_pkg::WORD_W-1:0]   pal_rdata
);
    import rrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_PAL_RD,
        S_PAL_WAIT,
        S_PAL_WR,
        S_LINE_RD,
        S_LINE_WAIT,
        S_RESP
    } state_t;

    state_t               state_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     limit_reg;
    logic [WORD_W-1:0]    value_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [WORD_W-1:0]    color_reg;
    logic [WORD_W-1:0]    pixel_reg;
    logic [1:0]           status_reg;
    logic                 out_valid_reg;
    logic [WORD_W-1:0]    out_pixel_reg;
    logic [1:0]           out_status_reg;

    logic                 accept;
    logic [COL_W-1:0]     width;
    logic [COL_W-1:0]     end_clamped;
    logic                 end_over;
    logic                 pal_in_range;
    logic [WORD_W-1:0]    label_value;
    logic [COL_W-1:0]     col_next;
    logic                 out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // saturate the width in use to the line depth
    assign width = (32'(cfg.row_width) > LINE_DEPTH) ? COL_W'(LINE_DEPTH) : cfg.row_width;
    assign end_over     = (in_item.run_end > width);
    assign end_clamped  = end_over ? width : in_item.run_end;
    assign pal_in_range = (32'(in_item.run_label) < PALETTE_DEPTH);
    assign label_value  = 32'(in_item.run_label) + 32'(cfg.label_offset);
    assign col_next     = col_reg + COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= '0;
            limit_reg      <= '0;
            value_reg      <= '0;
            label_reg      <= '0;
            color_reg      <= '0;
            pixel_reg      <= '0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_pixel_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // drop the response once taken, unless a new one is loaded below
            if (out_valid_reg && out_ready && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        label_reg  <= in_item.run_label;
                        color_reg  <= in_item.color_word;
                        pixel_reg  <= '0;
                        status_reg <= ST_OK;
                        unique case (in_item.req_type)
                            REQ_START_ROW:
                            begin
                                col_reg   <= '0;
                                limit_reg <= width;
                                value_reg <= cfg.background_value;
                                state_reg <= (width != '0) ? S_SWEEP : S_RESP;
                            end
                            REQ_PAINT_RUN:
                            begin
                                col_reg    <= in_item.run_first;
                                limit_reg  <= end_clamped;
                                status_reg <= end_over ? ST_CLAMPED : ST_OK;
                                if (cfg.display_mode == MODE_PALETTE)
                                begin
                                    if (pal_in_range)
                                    begin
                                        state_reg <= S_PAL_RD;
                                    end
                                    else
                                    begin
                                        status_reg <= ST_RANGE;
                                        state_reg  <= S_RESP;
                                    end
                                end
                                else
                                begin
                                    value_reg <= (cfg.display_mode == MODE_MASK) ?
                                                 MASK_VALUE : label_value;
                                    state_reg <= (in_item.run_first < end_clamped) ?
                                                 S_SWEEP : S_RESP;
                                end
                            end
                            REQ_PAL_WRITE:
                            begin
                                if (pal_in_range)
                                begin
                                    state_reg <= S_PAL_WR;
                                end
                                else
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_RESP;
                                end
                            end
                            REQ_READ_PIX:
                            begin
                                col_reg <= in_item.run_first;
                                if (in_item.run_first < width)
                                begin
                                    state_reg <= S_LINE_RD;
                                end
                                else
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_RESP;
                                end
                            end
                        endcase
                    end
                end
                S_SWEEP:
                begin
                    col_reg <= col_next;
                    if (col_next == limit_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_PAL_RD:
                begin
                    state_reg <= S_PAL_WAIT;
                end
                S_PAL_WAIT:
                begin
                    value_reg <= pal_rdata;
                    state_reg <= (col_reg < limit_reg) ? S_SWEEP : S_RESP;
                end
                S_PAL_WR:
                begin
                    state_reg <= S_RESP;
                end
                S_LINE_RD:
                begin
                    state_reg <= S_LINE_WAIT;
                end
                S_LINE_WAIT:
                begin
                    pixel_reg <= line_rdata;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_pixel_reg  <= pixel_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        line_req.we    = (state_reg == S_SWEEP);
        line_req.re    = (state_reg == S_LINE_RD);
        line_req.addr  = LINE_AW'(col_reg);
        line_req.wdata = value_reg;
        pal_req.we     = (state_reg == S_PAL_WR);
        pal_req.re     = (state_reg == S_PAL_RD);
        pal_req.addr   = PAL_AW'(label_reg);
        pal_req.wdata  = color_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_status = out_status_reg;

    `RRR_ASSERT_SAME(a_sweep_below_limit, clk, rst_n, line_req.we, col_reg < limit_reg)
    `RRR_ASSERT_SAME(a_pal_write_in_range, clk, rst_n, pal_req.we, 32'(label_reg) < PALETTE_DEPTH)
    `RRR_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, accept, state_reg != S_IDLE)
    `RRR_ASSERT_SAME(a_no_overlap_access, clk, rst_n, line_req.we, !line_req.re && !pal_req.re)

endmodule
